>>> hdl/zpnf_pkg.sv
package zpnf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int REG_W      = 11;
	localparam int REG_IDX_W  = 2;

	// register map
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// average of three neighbors: sum * 683 >> 11 is exact for sums up to 765
	localparam int SUM_W        = PIX_W + 2;
	localparam int RECIP3       = 683;
	localparam int RECIP3_W     = 10;
	localparam int RECIP3_SHIFT = 11;
	localparam int PROD_W       = SUM_W + RECIP3_W;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} out_word_t;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// zero counts as one, anything above the limit counts as the limit
	function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
		input logic [REG_W-1:0] lim);
		logic [REG_W-1:0] res;
		if (v == '0) begin
			res = REG_W'(1);
		end else if (v > lim) begin
			res = lim;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

>>> hdl/zpnf_if.sv
interface zpnf_in_if;
	import zpnf_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface zpnf_out_if;
	import zpnf_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/zpnf_ram.sv
module zpnf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

>>> hdl/zpnf_fill.sv
module zpnf_fill (
	input  logic [zpnf_pkg::PIX_W-1:0] centre,
	input  logic [zpnf_pkg::PIX_W-1:0] up,
	input  logic [zpnf_pkg::PIX_W-1:0] down,
	input  logic [zpnf_pkg::PIX_W-1:0] left_px,
	input  logic [zpnf_pkg::PIX_W-1:0] right_px,
	output logic [zpnf_pkg::PIX_W-1:0] result
);
	import zpnf_pkg::*;

	logic [3:0]        nz;
	logic [SUM_W-1:0]  sum;
	logic [2:0]        cnt;
	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  avg;

	// zero neighbors add nothing to the sum, only the count skips them
	assign nz   = {up != '0, down != '0, left_px != '0, right_px != '0};
	assign sum  = SUM_W'(up) + SUM_W'(down) + SUM_W'(left_px) + SUM_W'(right_px);
	assign cnt  = 3'(nz[0]) + 3'(nz[1]) + 3'(nz[2]) + 3'(nz[3]);
	assign prod = PROD_W'(sum) * PROD_W'(RECIP3);

	always_comb begin
		case (cnt)
			3'd0:    avg = '0;
			3'd1:    avg = sum[PIX_W-1:0];
			3'd2:    avg = sum[PIX_W:1];
			3'd3:    avg = prod[RECIP3_SHIFT +: PIX_W];
			default: avg = sum[PIX_W+1:2];
		endcase
	end

	assign result = (centre != '0) ? centre : avg;

endmodule

>>> hdl/zero_pixel_neighbor_fill.sv
// channel  | dir | payload                          | accepted when
// px_in    | in  | cmd, pixel_in                    | px_in.valid && px_in.ready
// px_out   | out | pixel_out, row_end, frame_end    | px_out.valid && px_out.ready
// cfg      | in  | wr_index, wr_data                | wr_en
//
// a pixel word goes through accept and row ram read, capture and write back;
// a flush word that emits a result adds a row ram read for the left neighbor
// between capture and write back; a flush word with nothing pending is only
// accepted; the two row rams are read-modify-written, one word in flight at a time
// px_in.ready is high only between words; a full output register stalls a result
// at write back; arst_n clears counters, state and output valid, not the row rams
module zero_pixel_neighbor_fill (
	input  logic                           clk,
	input  logic                           arst_n,
	zpnf_in_if.sink                        px_in,
	zpnf_out_if.source                     px_out,
	input  logic                           wr_en,
	input  logic [zpnf_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [zpnf_pkg::REG_W-1:0]     wr_data
);
	import zpnf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CAP  = 2'd1;
	localparam logic [1:0] ST_LEFT = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	// configuration
	logic [REG_W-1:0] width_q, height_q;
	logic [REG_W-1:0] w_eff, h_eff;

	// raster position of the next input and of the next pending last-row result
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic             tail_q;
	logic [1:0]       state_q;

	// word in flight
	logic             cmd_s1, has_res_s1, up_ok_s1, left_ok_s1, right_ok_s1;
	logic             row_end_s1, frame_end_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] pix_s1;

	// neighborhood captured from the row rams
	logic [PIX_W-1:0] ctr_s2, up_s2, left_s2, right_s2;

	// output register
	logic      out_valid_q;
	out_word_t out_word_q;

	// row rams
	logic [COL_W-1:0] old_ra0, old_ra1, mid_ra0, mid_ra1;
	logic [PIX_W-1:0] old_rd0, old_rd1, mid_rd0, mid_rd1;
	logic             wb_en;

	// accept-time decode
	logic             accept, is_pixel, work;
	logic [COL_W-1:0] acc_col;
	logic [ROW_W-1:0] acc_row;
	logic             acc_row_last, acc_frame_last;
	logic             proceed;
	logic [PIX_W-1:0] fill_px;

	assign w_eff = clamp_dim(width_q, REG_W'(MAX_WIDTH));
	assign h_eff = clamp_dim(height_q, REG_W'(MAX_HEIGHT));

	// config writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= REG_W'(MAX_WIDTH);
			height_q <= REG_W'(MAX_HEIGHT);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_WIDTH:  width_q  <= wr_data;
				REG_FRAME_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign px_in.ready = (state_q == ST_IDLE);
	assign accept      = px_in.valid && px_in.ready;
	assign is_pixel    = (px_in.data.cmd == CMD_PIXEL);
	// a flush with nothing pending is swallowed without work
	assign work        = accept && (is_pixel || tail_q);

	// a pixel while the last row waits starts a new frame
	assign acc_col = is_pixel ? (tail_q ? '0 : in_col_q) : out_col_q;
	assign acc_row = is_pixel ? (tail_q ? '0 : in_row_q) : out_row_q;

	assign acc_row_last   = (REG_W'(acc_col) + REG_W'(1)) >= w_eff;
	assign acc_frame_last = acc_row_last && ((REG_W'(acc_row) + REG_W'(1)) >= h_eff);

	// read addresses: up and center at the column, left from the older row
	// for pixels, right from the middle row; the flush left read goes later
	assign old_ra0 = acc_col;
	assign old_ra1 = acc_col - COL_W'(1);
	assign mid_ra0 = acc_col;
	assign mid_ra1 = (state_q == ST_CAP) ? (col_s1 - COL_W'(1)) : (acc_col + COL_W'(1));

	// counters move at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			tail_q    <= 1'b0;
		end else if (work) begin
			if (is_pixel) begin
				if (acc_frame_last) begin
					tail_q    <= 1'b1;
					out_row_q <= acc_row;
					out_col_q <= '0;
					in_col_q  <= '0;
					in_row_q  <= '0;
				end else begin
					tail_q    <= 1'b0;
					out_row_q <= '0;
					out_col_q <= '0;
					if (acc_row_last) begin
						in_col_q <= '0;
						in_row_q <= acc_row + ROW_W'(1);
					end else begin
						in_col_q <= acc_col + COL_W'(1);
						in_row_q <= acc_row;
					end
				end
			end else if (acc_row_last) begin
				tail_q    <= 1'b0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				out_col_q <= acc_col + COL_W'(1);
			end
		end
	end

	// item decode, held for the whole sequence
	always_ff @(posedge clk) begin
		if (work) begin
			cmd_s1      <= px_in.data.cmd;
			col_s1      <= acc_col;
			pix_s1      <= is_pixel ? px_in.data.pixel_in : '0;
			has_res_s1  <= is_pixel ? (acc_row >= ROW_W'(1)) : 1'b1;
			up_ok_s1    <= is_pixel ? (acc_row >= ROW_W'(2)) : (acc_row >= ROW_W'(1));
			left_ok_s1  <= (acc_col != '0);
			right_ok_s1 <= !acc_row_last;
			row_end_s1  <= acc_row_last;
			// a pixel marks frame end only past a height lowered mid-frame
			frame_end_s1 <= is_pixel ? (acc_row_last && (REG_W'(acc_row) >= h_eff))
				: acc_row_last;
		end
	end

	// capture ram data, neighbors outside the frame read as zero
	always_ff @(posedge clk) begin
		if (state_q == ST_CAP) begin
			ctr_s2   <= mid_rd0;
			up_s2    <= up_ok_s1 ? old_rd0 : '0;
			right_s2 <= right_ok_s1 ? mid_rd1 : '0;
			left_s2  <= left_ok_s1 ? old_rd1 : '0;
		end else if (state_q == ST_LEFT) begin
			left_s2  <= left_ok_s1 ? mid_rd1 : '0;
		end
	end

	assign proceed = !has_res_s1 || !out_valid_q || px_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (work) state_q <= ST_CAP;
				ST_CAP:  state_q <= (cmd_s1 == CMD_FLUSH) ? ST_LEFT : ST_WR;
				ST_LEFT: state_q <= ST_WR;
				ST_WR:   if (proceed) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	zpnf_fill u_fill (
		.centre   (ctr_s2),
		.up       (up_s2),
		.down     (pix_s1),
		.left_px  (left_s2),
		.right_px (right_s2),
		.result   (fill_px)
	);

	// write back: the middle row moves down, the new pixel enters the middle row
	assign wb_en = (state_q == ST_WR) && proceed && (cmd_s1 == CMD_PIXEL);

	zpnf_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_older_row (
		.clk    (clk),
		.we     (wb_en),
		.waddr  (col_s1),
		.wdata  (ctr_s2),
		.raddr0 (old_ra0),
		.rdata0 (old_rd0),
		.raddr1 (old_ra1),
		.rdata1 (old_rd1)
	);

	zpnf_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_middle_row (
		.clk    (clk),
		.we     (wb_en),
		.waddr  (col_s1),
		.wdata  (pix_s1),
		.raddr0 (mid_ra0),
		.rdata0 (mid_rd0),
		.raddr1 (mid_ra1),
		.rdata1 (mid_rd1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_WR) && proceed && has_res_s1) begin
			out_valid_q <= 1'b1;
		end else if (px_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WR) && proceed && has_res_s1) begin
			out_word_q.pixel_out <= fill_px;
			out_word_q.row_end   <= row_end_s1;
			out_word_q.frame_end <= frame_end_s1;
		end
	end

	assign px_out.valid = out_valid_q;
	assign px_out.data  = out_word_q;

endmodule
